[hw/rtl/brrm_pkg.sv]
// Shared types and constants of the bitmap run region map.
package brrm_pkg;

  localparam int POS_W    = 48;
  localparam int LIMIT_W  = 41;
  localparam int QUERY_W  = 40;
  localparam int TOTAL_W  = 11;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 41'h100_0000_0000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BYTE   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_RANGE  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DESCRIPTOR_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT      = 2'd1;

endpackage

[hw/rtl/brrm_region_mem.sv]
// Region table memory: one write port and one read port with registered read data.
module brrm_region_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/bitmap_run_region_map_unit.sv]
// Top level of the bitmap run region map: sequencer, multiplier, shared adder and region table.
//
//   port group | direction | handshake         | payload
//   in_        | input     | in_valid/in_stall | opcode, bitmap_byte, last_byte, query_page
//   out_       | output    | out_valid/out_stall | status, descriptor_position, region_total
//   cfg_       | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A bitmap byte steps through S_BIT, and S_CL_MUL and S_CL_ADD for each run it closes. A lookup
// checks the limit in S_LK_START, then takes S_LK_LOOP and S_LK_CMP per search step (at most
// log2(MAX_REGIONS)+1) and S_LK_MUL, S_LK_ADD when found. Clear and the unused opcode go to S_DONE.
// The block accepts an item only when idle, from the cycle after the previous result is loaded.
// Reset is synchronous; the region table is not cleared, the entry count bounds every read.
// A result held by out_stall does not stop the next item from being accepted.
module bitmap_run_region_map_unit
  import brrm_pkg::*;
#(
  parameter int MAX_REGIONS = 1024,
  parameter int PAGE_BITS   = 40,
  parameter int DESC_BYTES  = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OPCODE_W-1:0]  in_opcode,
  input  logic [7:0]           in_bitmap_byte,
  input  logic                 in_last_byte,
  input  logic [QUERY_W-1:0]   in_query_page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [POS_W-1:0]     out_descriptor_position,
  output logic [TOTAL_W-1:0]   out_region_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  localparam int AW     = $clog2(MAX_REGIONS);
  localparam int CW     = $clog2(MAX_REGIONS + 1);
  localparam int DW     = 2 * PAGE_BITS + POS_W;
  localparam int CMPW   = (PAGE_BITS > LIMIT_W) ? PAGE_BITS : LIMIT_W;
  localparam logic [CW-1:0]    MAX_CNT = CW'(MAX_REGIONS);
  localparam logic [POS_W-1:0] DESC_K  = POS_W'(DESC_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_BIT, S_CL_MUL, S_CL_ADD, S_LK_START,
    S_LK_LOOP, S_LK_CMP, S_LK_MUL, S_LK_ADD, S_DONE
  } state_t;

  state_t               state_r;
  logic [7:0]           byte_r;
  logic                 last_r;
  logic [PAGE_BITS-1:0] q_page_r;
  logic [3:0]           bit_cnt_r;
  logic [PAGE_BITS-1:0] cur_page_r;
  logic                 full_r;

  logic [POS_W-1:0]     base_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [CW-1:0]        count_r;
  logic                 run_open_r;
  logic [PAGE_BITS-1:0] run_start_r;
  logic [PAGE_BITS-1:0] next_page_r;
  logic [POS_W-1:0]     running_pos_r;

  logic [PAGE_BITS-1:0] len_r;
  logic [POS_W-1:0]     prod_r;
  logic [CW-1:0]        left_r;
  logic [CW-1:0]        right_r;
  logic [CW-1:0]        mid_r;

  status_t              res_status_r;
  logic [POS_W-1:0]     res_pos_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [TOTAL_W-1:0]   out_total_r;

  logic                 mem_we;
  logic                 mem_re;
  logic [DW-1:0]        mem_wdata;
  logic [DW-1:0]        mem_rdata;
  logic [CW-1:0]        mid;
  logic [PAGE_BITS-1:0] rd_start;
  logic [PAGE_BITS-1:0] rd_len;
  logic [POS_W-1:0]     rd_pos;
  logic [PAGE_BITS-1:0] diff;
  logic [POS_W-1:0]     add_a;
  logic [POS_W-1:0]     add_sum;
  logic                 cur_bit;

  brrm_region_mem #(
    .DEPTH  (MAX_REGIONS),
    .DATA_W (DW)
  ) u_region_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mid[AW-1:0]),
    .rd_data (mem_rdata)
  );

  assign mem_we    = (state_r == S_CL_MUL) && (count_r < MAX_CNT);
  assign mem_wdata = {run_start_r, len_r, running_pos_r};
  assign mid       = left_r + ((right_r - left_r) >> 1);
  assign mem_re    = (state_r == S_LK_LOOP) && (left_r != right_r);

  assign rd_start = mem_rdata[DW-1 -: PAGE_BITS];
  assign rd_len   = mem_rdata[POS_W +: PAGE_BITS];
  assign rd_pos   = mem_rdata[POS_W-1:0];
  assign diff     = q_page_r - rd_start;
  assign cur_bit  = byte_r[bit_cnt_r[2:0]];

  // The one adder serves both the running position and the found descriptor position.
  assign add_a   = (state_r == S_LK_ADD) ? rd_pos : running_pos_r;
  assign add_sum = add_a + prod_r;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_descriptor_position = out_pos_r;
  assign out_region_total        = out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      base_r        <= '0;
      limit_r       <= LIMIT_RESET;
      count_r       <= '0;
      run_open_r    <= 1'b0;
      run_start_r   <= '0;
      next_page_r   <= '0;
      running_pos_r <= '0;
      full_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_DESCRIPTOR_BASE) begin
          base_r <= cfg_data;
          // The base only moves the running position before the first byte of a map.
          if (next_page_r == '0) begin
            running_pos_r <= cfg_data;
          end
        end else if (cfg_index == CFG_PAGE_LIMIT) begin
          limit_r <= cfg_data[LIMIT_W-1:0];
        end
      end

      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            byte_r     <= in_bitmap_byte;
            last_r     <= in_last_byte;
            q_page_r   <= PAGE_BITS'(in_query_page);
            bit_cnt_r  <= '0;
            cur_page_r <= next_page_r;
            full_r     <= 1'b0;
            res_status_r <= ST_OK;
            res_pos_r    <= '0;
            unique case (opcode_t'(in_opcode))
              OP_BYTE:   state_r <= S_BIT;
              OP_LOOKUP: state_r <= S_LK_START;
              OP_CLEAR: begin
                count_r       <= '0;
                run_open_r    <= 1'b0;
                run_start_r   <= '0;
                next_page_r   <= '0;
                running_pos_r <= base_r;
                state_r       <= S_DONE;
              end
              OP_NONE:   state_r <= S_DONE;
              default:   state_r <= S_DONE;
            endcase
          end
        end

        S_BIT: begin
          if (!bit_cnt_r[3]) begin
            if (cur_bit) begin
              if (!run_open_r) begin
                run_open_r  <= 1'b1;
                run_start_r <= cur_page_r;
              end
            end else if (run_open_r) begin
              len_r      <= cur_page_r - run_start_r;
              run_open_r <= 1'b0;
              state_r    <= S_CL_MUL;
            end
            cur_page_r <= cur_page_r + 1'b1;
            bit_cnt_r  <= bit_cnt_r + 1'b1;
          end else if (bit_cnt_r == 4'd8) begin
            next_page_r <= cur_page_r;
            bit_cnt_r   <= bit_cnt_r + 1'b1;
            if (last_r && run_open_r) begin
              len_r      <= cur_page_r - run_start_r;
              run_open_r <= 1'b0;
              state_r    <= S_CL_MUL;
            end
          end else begin
            res_status_r <= full_r ? ST_FULL : ST_OK;
            state_r      <= S_DONE;
          end
        end

        S_CL_MUL: begin
          // A run closed on a full table is dropped but its descriptors still count.
          if (count_r < MAX_CNT) begin
            count_r <= count_r + 1'b1;
          end else begin
            full_r <= 1'b1;
          end
          prod_r  <= POS_W'(len_r) * DESC_K;
          state_r <= S_CL_ADD;
        end

        S_CL_ADD: begin
          running_pos_r <= add_sum;
          state_r       <= S_BIT;
        end

        S_LK_START: begin
          if (CMPW'(q_page_r) >= CMPW'(limit_r)) begin
            res_status_r <= ST_RANGE;
            state_r      <= S_DONE;
          end else begin
            left_r  <= '0;
            right_r <= count_r;
            state_r <= S_LK_LOOP;
          end
        end

        S_LK_LOOP: begin
          if (left_r == right_r) begin
            res_status_r <= ST_ABSENT;
            state_r      <= S_DONE;
          end else begin
            mid_r   <= mid;
            state_r <= S_LK_CMP;
          end
        end

        S_LK_CMP: begin
          if (q_page_r < rd_start) begin
            right_r <= mid_r;
            state_r <= S_LK_LOOP;
          end else if (diff >= rd_len) begin
            left_r  <= mid_r + 1'b1;
            state_r <= S_LK_LOOP;
          end else begin
            len_r   <= diff;
            state_r <= S_LK_MUL;
          end
        end

        S_LK_MUL: begin
          prod_r  <= POS_W'(len_r) * DESC_K;
          state_r <= S_LK_ADD;
        end

        S_LK_ADD: begin
          res_pos_r    <= add_sum;
          res_status_r <= ST_OK;
          state_r      <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_pos_r    <= res_pos_r;
            out_total_r  <= TOTAL_W'(count_r);
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("region count exceeds table size");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (count_r == $past(count_r) + 1'b1))
    else $error("table write without count advance");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LK_LOOP) |-> (left_r <= right_r && right_r <= count_r))
    else $error("search window outside stored regions");

  a_pos_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_pos_r == '0))
    else $error("descriptor position given without a hit");

endmodule
